// ----- sv/vsc_pkg.sv -----
// Shared constants, types and character-class helpers for the version string comparator.
// No dependencies.
`default_nettype none

package vsc_pkg;

  localparam logic [1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [1:0] FUNC_COMPARE       = 2'd2;

  localparam logic signed [1:0] ORDER_OLDER = -2'sd1;
  localparam logic signed [1:0] ORDER_SAME  = 2'sd0;
  localparam logic signed [1:0] ORDER_NEWER = 2'sd1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic              done;
    logic signed [1:0] order;
  } vsc_res_t;

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_let(input logic [7:0] c);
    is_let = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_aln(input logic [7:0] c);
    is_aln = is_dig(c) || is_let(c);
  endfunction

endpackage

`default_nettype wire

// ----- sv/vsc_store.sv -----
// Byte store for one version string: one write port, one registered read port.
// No dependencies.
`default_nettype none

module vsc_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/vsc_walk.sv -----
// Segment walker: steps both stores one byte per cycle and decides the order.
// Depends on vsc_pkg.
`default_nettype none

module vsc_walk #(
  parameter int LEN_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [LEN_W-1:0] la_i,
  input  wire logic [LEN_W-1:0] lb_i,
  input  wire logic [7:0]       rdata_a_i,
  input  wire logic [7:0]       rdata_b_i,
  output      logic [LEN_W-1:0] raddr_a_o,
  output      logic [LEN_W-1:0] raddr_b_o,
  output      logic             busy_o,
  output      vsc_pkg::vsc_res_t res_o
);

  import vsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EQ, S_TOP, S_SKIP, S_SCAN, S_ZERO, S_CMP
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [LEN_W-1:0] ea_q, ea_d, eb_q, eb_d;
  logic [LEN_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic             let_q, let_d;
  logic [7:0]       ca, cb;
  logic             a_go, b_go, a_more, b_more;
  logic [LEN_W-1:0] na, nb;

  // bytes at or past the end read as zero
  assign ca = (ia_q < la_i) ? rdata_a_i : 8'h00;
  assign cb = (ib_q < lb_i) ? rdata_b_i : 8'h00;
  assign na = ea_q - pa_q;
  assign nb = eb_q - pb_q;

  always_comb begin
    state_d   = state_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    let_d     = let_q;
    res_o     = '0;
    a_go      = 1'b0;
    b_go      = 1'b0;
    a_more    = 1'b0;
    b_more    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ia_d    = '0;
          ib_d    = '0;
          pa_d    = '0;
          pb_d    = '0;
          state_d = (la_i == lb_i) ? S_EQ : S_TOP;
        end
      end
      S_EQ: begin
        if (ia_q == la_i) begin
          res_o   = '{done: 1'b1, order: ORDER_SAME};
          state_d = S_IDLE;
        end else if (ca != cb) begin
          state_d = S_TOP;
        end else if (ca == 8'h00) begin
          res_o   = '{done: 1'b1, order: ORDER_SAME};
          state_d = S_IDLE;
        end else begin
          ia_d = ia_q + 1'b1;
          ib_d = ib_q + 1'b1;
        end
      end
      S_TOP: begin
        if ((pa_q == la_i) || (pb_q == lb_i)) begin
          res_o.done = 1'b1;
          if ((pa_q == la_i) && (pb_q == lb_i)) begin
            res_o.order = ORDER_SAME;
          end else if (pa_q != la_i) begin
            res_o.order = ORDER_NEWER;
          end else begin
            res_o.order = ORDER_OLDER;
          end
          state_d = S_IDLE;
        end else begin
          ia_d    = pa_q;
          ib_d    = pb_q;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        a_go = (pa_q != la_i) && !is_aln(ca);
        b_go = (pb_q != lb_i) && !is_aln(cb);
        if (a_go) begin
          pa_d = pa_q + 1'b1;
          ia_d = pa_q + 1'b1;
        end
        if (b_go) begin
          pb_d = pb_q + 1'b1;
          ib_d = pb_q + 1'b1;
        end
        if (!a_go && !b_go) begin
          if (!is_dig(cb) && is_dig(ca)) begin
            res_o   = '{done: 1'b1, order: ORDER_NEWER};
            state_d = S_IDLE;
          end else if (is_let(ca) && is_dig(cb)) begin
            res_o   = '{done: 1'b1, order: ORDER_OLDER};
            state_d = S_IDLE;
          end else begin
            let_d   = is_let(ca);
            ea_d    = pa_q;
            eb_d    = pb_q;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        a_go = (ea_q != la_i) && (let_q ? is_let(ca) : is_dig(ca));
        b_go = (eb_q != lb_i) && (let_q ? is_let(cb) : is_dig(cb));
        if (a_go) begin
          ea_d = ea_q + 1'b1;
          ia_d = ea_q + 1'b1;
        end
        if (b_go) begin
          eb_d = eb_q + 1'b1;
          ib_d = eb_q + 1'b1;
        end
        if (!a_go && !b_go) begin
          ia_d    = pa_q;
          ib_d    = pb_q;
          state_d = let_q ? S_CMP : S_ZERO;
        end
      end
      S_ZERO: begin
        a_go = (pa_q != ea_q) && (ca == CHAR_ZERO);
        b_go = (pb_q != eb_q) && (cb == CHAR_ZERO);
        if (a_go) begin
          pa_d = pa_q + 1'b1;
          ia_d = pa_q + 1'b1;
        end
        if (b_go) begin
          pb_d = pb_q + 1'b1;
          ib_d = pb_q + 1'b1;
        end
        if (!a_go && !b_go) begin
          if (na > nb) begin
            res_o   = '{done: 1'b1, order: ORDER_NEWER};
            state_d = S_IDLE;
          end else if (nb > na) begin
            res_o   = '{done: 1'b1, order: ORDER_OLDER};
            state_d = S_IDLE;
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        a_more = (pa_q != ea_q);
        b_more = (pb_q != eb_q);
        if (a_more && b_more && (ca == cb)) begin
          pa_d = pa_q + 1'b1;
          pb_d = pb_q + 1'b1;
          ia_d = pa_q + 1'b1;
          ib_d = pb_q + 1'b1;
        end else if (a_more && b_more) begin
          res_o   = '{done: 1'b1, order: (ca > cb) ? ORDER_NEWER : ORDER_OLDER};
          state_d = S_IDLE;
        end else if (a_more) begin
          res_o   = '{done: 1'b1, order: ORDER_NEWER};
          state_d = S_IDLE;
        end else if (b_more) begin
          res_o   = '{done: 1'b1, order: ORDER_OLDER};
          state_d = S_IDLE;
        end else begin
          pa_d    = ea_q;
          pb_d    = eb_q;
          state_d = S_TOP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pa_q    <= '0;
      pb_q    <= '0;
      ea_q    <= '0;
      eb_q    <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      let_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      ea_q    <= ea_d;
      eb_q    <= eb_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
      let_q   <= let_d;
    end
  end

  // read address follows the next cursor so data lines up with the cursor
  assign raddr_a_o = ia_d;
  assign raddr_b_o = ib_d;
  assign busy_o    = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/version_string_compare.sv -----
// Top level of the version string comparator: append control, two byte stores, walker.
// Depends on vsc_pkg, vsc_store and vsc_walk.
//
// Usage: present func_i and ch_i with start; a transfer happens at a rising edge where
// start is high and busy is low. func 0 appends ch_i to the first string, func 1 to the
// second; an append leaves busy low, so bytes load back to back.
// A byte beyond MAX_LEN is dropped and the overflow flag is set. func 3 does nothing.
// func 2 starts a compare: busy rises the next cycle while the walker steps both stores,
// at most one byte position per cycle per store, through separators, segments, leading
// zeros and segment bytes. The result appears on order_o and overflow_o for exactly one
// cycle with done_o high, in the cycle in which busy falls; both strings and the overflow
// flag are then cleared.
// The receiver cannot stall: done_o is a one-cycle strobe.
// Reset clears both lengths, the overflow flag and the walker; store contents are not
// cleared; bytes beyond the current lengths read as zero in the walker.
`default_nettype none

module version_string_compare #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [1:0]        func_i,
  input  wire logic [7:0]        ch_i,
  output      logic              done_o,
  output      logic signed [1:0] order_o,
  output      logic              overflow_o
);

  import vsc_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [LEN_W-1:0]  la_q, la_d, lb_q, lb_d;
  logic              trunc_q, trunc_d;
  logic              done_q;
  logic signed [1:0] order_q;
  logic              ovf_q;
  logic              accept, we_a, we_b, cmp_start;
  logic [LEN_W-1:0]  raddr_a, raddr_b;
  logic [7:0]        rdata_a, rdata_b;
  logic              walk_busy;
  vsc_res_t          res;

  assign accept    = start && !busy;
  assign we_a      = accept && (func_i == FUNC_APPEND_FIRST) && (la_q < LEN_W'(MAX_LEN));
  assign we_b      = accept && (func_i == FUNC_APPEND_SECOND) && (lb_q < LEN_W'(MAX_LEN));
  assign cmp_start = accept && (func_i == FUNC_COMPARE);

  always_comb begin
    la_d    = la_q;
    lb_d    = lb_q;
    trunc_d = trunc_q;
    if (res.done) begin
      la_d    = '0;
      lb_d    = '0;
      trunc_d = 1'b0;
    end else if (accept) begin
      case (func_i)
        FUNC_APPEND_FIRST: begin
          if (we_a) begin
            la_d = la_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
        end
        FUNC_APPEND_SECOND: begin
          if (we_b) begin
            lb_d = lb_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q    <= '0;
      lb_q    <= '0;
      trunc_q <= 1'b0;
      done_q  <= 1'b0;
      order_q <= ORDER_SAME;
      ovf_q   <= 1'b0;
    end else begin
      la_q    <= la_d;
      lb_q    <= lb_d;
      trunc_q <= trunc_d;
      done_q  <= res.done;
      if (res.done) begin
        order_q <= res.order;
        ovf_q   <= trunc_q;
      end
    end
  end

  vsc_store #(
    .DEPTH (MAX_LEN),
    .AW    (IDX_W)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (la_q[IDX_W-1:0]),
    .wdata_i (ch_i),
    .raddr_i (raddr_a[IDX_W-1:0]),
    .rdata_o (rdata_a)
  );

  vsc_store #(
    .DEPTH (MAX_LEN),
    .AW    (IDX_W)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (lb_q[IDX_W-1:0]),
    .wdata_i (ch_i),
    .raddr_i (raddr_b[IDX_W-1:0]),
    .rdata_o (rdata_b)
  );

  vsc_walk #(
    .LEN_W (LEN_W)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmp_start),
    .la_i      (la_q),
    .lb_i      (lb_q),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .busy_o    (walk_busy),
    .res_o     (res)
  );

  assign busy       = walk_busy;
  assign done_o     = done_q;
  assign order_o    = order_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

// ----- test/version_string_compare_tb.sv -----
// Self-checking testbench for version_string_compare: directed byte strings, then random
// version pairs loaded through the start/busy port and compared against a local predictor.
// Depends on vsc_pkg and version_string_compare.
`timescale 1ns / 1ps

module version_string_compare_tb;
  import vsc_pkg::*;

  localparam int unsigned STORE_DEPTH    = 64;
  localparam int unsigned RANDOM_ITEMS   = 700;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [1:0]  FUNC_NOP       = 2'd3;

  typedef struct packed {
    logic [1:0]        f;
    logic [7:0]        c;
    logic              pinned;
    logic signed [1:0] ord;
    logic              ovf;
  } step_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              ovf;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        func;
  logic [7:0]        ch;
  logic              done_o;
  logic signed [1:0] order_o;
  logic              overflow_o;

  logic              row_pinned;
  logic signed [1:0] row_order;
  logic              row_ovf;

  logic [7:0]  chars_a [STORE_DEPTH];
  logic [7:0]  chars_b [STORE_DEPTH];
  int unsigned len_a;
  int unsigned len_b;
  logic        dropped;

  verdict_t    pending_verdicts[$];
  int unsigned xfer_count;
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          moved;

  logic [7:0]  str_a[$];
  logic [7:0]  str_b[$];
  logic [7:0]  scratch[$];
  step_t       script[$];

  version_string_compare u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func),
    .ch_i       (ch),
    .done_o     (done_o),
    .order_o    (order_o),
    .overflow_o (overflow_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit word_byte(input logic [7:0] c);
    return digit_byte(c) || letter_byte(c);
  endfunction

  function automatic logic [7:0] read_a(input int unsigned i);
    return (i < len_a) ? chars_a[i] : 8'h00;
  endfunction

  function automatic logic [7:0] read_b(input int unsigned i);
    return (i < len_b) ? chars_b[i] : 8'h00;
  endfunction

  function automatic logic signed [1:0] predict_order();
    int unsigned la, lb, pa, pb, ea, eb, i, na, nb;
    logic [7:0]  ca, cb;
    bit          same, more;
    la = len_a;
    lb = len_b;
    pa = 0;
    pb = 0;
    if (la == lb) begin
      same = 1'b1;
      more = 1'b1;
      for (i = 0; i < la && more; i++) begin
        if (read_a(i) != read_b(i)) begin
          same = 1'b0;
          more = 1'b0;
        end else if (read_a(i) == 8'h00) begin
          more = 1'b0;
        end
      end
      if (same) return ORDER_SAME;
    end
    while (pa != la && pb != lb) begin
      while (pa != la && !word_byte(read_a(pa))) pa++;
      while (pb != lb && !word_byte(read_b(pb))) pb++;
      ea = pa;
      eb = pb;
      ca = read_a(pa);
      cb = read_b(pb);
      if (digit_byte(ca) && !digit_byte(cb)) return ORDER_NEWER;
      if (letter_byte(ca) && digit_byte(cb)) return ORDER_OLDER;
      if (letter_byte(ca)) begin
        while (ea != la && letter_byte(read_a(ea))) ea++;
        while (eb != lb && letter_byte(read_b(eb))) eb++;
      end else begin
        while (ea != la && digit_byte(read_a(ea))) ea++;
        while (eb != lb && digit_byte(read_b(eb))) eb++;
        while (pa != ea && read_a(pa) == CHAR_ZERO) pa++;
        while (pb != eb && read_b(pb) == CHAR_ZERO) pb++;
        na = ea - pa;
        nb = eb - pb;
        if (na > nb) return ORDER_NEWER;
        if (nb > na) return ORDER_OLDER;
      end
      while (pa != ea && pb != eb && read_a(pa) == read_b(pb)) begin
        pa++;
        pb++;
      end
      if (pa != ea && pb != eb) return (read_a(pa) > read_b(pb)) ? ORDER_NEWER : ORDER_OLDER;
      if (pa != ea) return ORDER_NEWER;
      if (pb != eb) return ORDER_OLDER;
      pa = ea;
      pb = eb;
    end
    if (pa == la && pb == lb) return ORDER_SAME;
    return (pa != la) ? ORDER_NEWER : ORDER_OLDER;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Predictor update for one accepted transfer.
  task automatic apply_transfer();
    verdict_t v;
    case (func)
      FUNC_APPEND_FIRST: begin
        if (len_a < STORE_DEPTH) begin
          chars_a[len_a] = ch;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_APPEND_SECOND: begin
        if (len_b < STORE_DEPTH) begin
          chars_b[len_b] = ch;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_COMPARE: begin
        v.order = predict_order();
        v.ovf   = dropped;
        if (row_pinned) begin
          v.order = row_order;
          v.ovf   = row_ovf;
        end
        pending_verdicts.push_back(v);
        len_a   = 0;
        len_b   = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    verdict_t v;
    if (pending_verdicts.size() == 0) begin
      report_mismatch("outstanding compares", 0, 1);
    end else begin
      v = pending_verdicts.pop_front();
      if (order_o !== v.order) report_mismatch("order", order_o, v.order);
      if (overflow_o !== v.ovf) report_mismatch("overflow", overflow_o, v.ovf);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        check_result();
      end
      if (start && !busy) begin
        moved = 1'b1;
        xfer_count++;
        apply_transfer();
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input logic [1:0] f, input logic [7:0] c, input bit pinned = 1'b0,
                           input logic signed [1:0] ord = ORDER_SAME, input logic ovf = 1'b0);
    int unsigned seen;
    seen = xfer_count;
    start      <= 1'b1;
    func       <= f;
    ch         <= c;
    row_pinned <= pinned;
    row_order  <= ord;
    row_ovf    <= ovf;
    do @(negedge clk_i); while (xfer_count == seen);
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic pause(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_word_byte();
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0) return 8'h30 + 8'($urandom_range(0, 9));
    if (r == 1) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  task automatic add_separator();
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r)
      0, 1, 2, 3: scratch.push_back(8'h2E);
      4:          scratch.push_back(8'h2D);
      5:          scratch.push_back(8'h5F);
      6:          scratch.push_back(8'h7E);
      7: begin
        scratch.push_back(8'h2E);
        scratch.push_back(8'h2E);
      end
      8:          scratch.push_back(8'h00);
      9:          scratch.push_back(8'($urandom_range(128, 255)));
      10:         scratch.push_back(8'($urandom_range(0, 47)));
      default: ;
    endcase
  endtask

  task automatic add_segment();
    int unsigned r, n, j;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        for (j = 0; j < n; j++) scratch.push_back(CHAR_ZERO);
      end
      n = $urandom_range(1, 4);
      for (j = 0; j < n; j++) scratch.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end else if (r < 8) begin
      n = $urandom_range(1, 3);
      for (j = 0; j < n; j++) begin
        scratch.push_back(($urandom_range(0, 3) == 0) ? 8'h41 + 8'($urandom_range(0, 25))
                                                      : 8'h61 + 8'($urandom_range(0, 25)));
      end
    end else begin
      scratch.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_version(input int unsigned nseg, input int unsigned max_bytes);
    int unsigned k;
    scratch.delete();
    if ($urandom_range(0, 9) == 0) add_separator();
    for (k = 0; k < nseg && scratch.size() < max_bytes; k++) begin
      if (k != 0) add_separator();
      add_segment();
    end
    if ($urandom_range(0, 9) == 0) add_separator();
  endtask

  task automatic build_pair();
    int unsigned m, j, n;
    logic [7:0]  t[$];
    if ($urandom_range(0, 19) == 0) build_version(100, STORE_DEPTH + $urandom_range(1, 6));
    else if ($urandom_range(0, 24) == 0) scratch.delete();
    else build_version($urandom_range(1, 5), STORE_DEPTH);
    str_a = scratch;
    m = $urandom_range(0, 9);
    str_b = str_a;
    if (m < 3) begin
    end else if (m < 5) begin
      if (str_b.size() != 0) str_b[$urandom_range(0, str_b.size() - 1)] = random_word_byte();
    end else if (m == 5) begin
      build_version($urandom_range(1, 2), 8);
      if ($urandom_range(0, 1) == 1) str_b.push_back(8'h2E);
      str_b = {str_b, scratch};
    end else if (m == 6) begin
      n = $urandom_range(1, 4);
      for (j = 0; j < n && str_b.size() != 0; j++) void'(str_b.pop_back());
    end else begin
      if ($urandom_range(0, 19) == 0) build_version(100, STORE_DEPTH + $urandom_range(1, 6));
      else build_version($urandom_range(1, 5), STORE_DEPTH);
      str_b = scratch;
    end
    if ($urandom_range(0, 1) == 1) begin
      t     = str_a;
      str_a = str_b;
      str_b = t;
    end
  endtask

  initial begin
    int unsigned items_sent, ia, ib;
    bit          steady;
    step_t       s;
    rst_ni       = 1'b0;
    start        = 1'b0;
    func         = FUNC_NOP;
    ch           = 8'h00;
    row_pinned   = 1'b0;
    row_order    = ORDER_SAME;
    row_ovf      = 1'b0;
    len_a        = 0;
    len_b        = 0;
    dropped      = 1'b0;
    xfer_count   = 0;
    error_count  = 0;
    quiet_cycles = 0;
    items_sent   = 0;

    // empty against empty, idle selector
    script.push_back(step_t'{FUNC_COMPARE,       8'h00, 1'b1, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_NOP,           8'hFF, 1'b0, ORDER_SAME,  1'b0});
    // longer digit run wins: "10" vs "9"
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "1",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "0",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "9",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'hFF, 1'b1, ORDER_NEWER, 1'b0});
    // digits beat letters
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "a",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "1",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'h00, 1'b1, ORDER_OLDER, 1'b0});
    // non-ASCII against zero byte
    script.push_back(step_t'{FUNC_APPEND_FIRST,  8'hFF, 1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, 8'h00, 1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'h55, 1'b0, ORDER_SAME,  1'b0});
    // letter segment prefix
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "a",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "b",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "a",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'hAA, 1'b0, ORDER_SAME,  1'b0});
    // leading zero, then letter tail against an ended string
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "0",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "7",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "7",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "z",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'h0F, 1'b0, ORDER_SAME,  1'b0});
    // identical strings
    script.push_back(step_t'{FUNC_APPEND_FIRST,  "x",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_APPEND_SECOND, "x",   1'b0, ORDER_SAME,  1'b0});
    script.push_back(step_t'{FUNC_COMPARE,       8'hF0, 1'b1, ORDER_SAME,  1'b0});

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      s = script[i];
      push_item(s.f, s.c, s.pinned, s.ord, s.ovf);
      pause(gap_len());
    end
    drain();

    while (items_sent < RANDOM_ITEMS) begin
      build_pair();
      steady = ($urandom_range(0, 3) == 0);
      ia = 0;
      ib = 0;
      while (ia < str_a.size() || ib < str_b.size()) begin
        if (ib >= str_b.size() || (ia < str_a.size() && $urandom_range(0, 1) == 1)) begin
          push_item(FUNC_APPEND_FIRST, str_a[ia]);
          ia++;
        end else begin
          push_item(FUNC_APPEND_SECOND, str_b[ib]);
          ib++;
        end
        items_sent++;
        if ($urandom_range(0, 39) == 0) push_item(FUNC_NOP, 8'($urandom_range(0, 255)));
        if (!steady) pause(gap_len());
      end
      push_item(FUNC_COMPARE, 8'($urandom_range(0, 255)));
      items_sent++;
      if ($urandom_range(0, 9) == 0) drain();
      else if (!steady) pause(gap_len());
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- version_string_compare.f -----
sv/vsc_pkg.sv
sv/vsc_store.sv
sv/vsc_walk.sv
sv/version_string_compare.sv
test/version_string_compare_tb.sv
